// ----- design/pfc_pkg.sv -----
// Package for the prime factor counter: operand and count widths and the
// constants of the trial division. No dependencies.
`timescale 1ns / 1ps

package pfc_pkg;

  // Width of the value port and default width of the factored operand.
  localparam int IN_BITS         = 32;
  localparam int VALUE_BITS_DEF  = 32;

  // Width of the factor count field.
  localparam int COUNT_BITS      = 6;

  // Trial division starts at the first prime.
  localparam int FIRST_DIVISOR   = 2;

  // A cofactor or operand above this value still holds a prime factor.
  localparam int UNIT_VALUE      = 1;

endpackage

// ----- design/prime_factor_count.sv -----
// Prime factor counter, with multiplicity, by trial division, top level.
// Depends on pfc_pkg for widths and constants.
`timescale 1ns / 1ps

// prime_factor_count takes one unsigned integer per request and returns the
// number of its prime factors, counted with multiplicity. Only the low
// VALUE_BITS bits of the value are factored; 0 and 1 give a count of 0.
// Candidate divisors run 2, 3, 5, 7, 9, ... while the divisor does not exceed
// the remaining value divided by it, and every exact division adds one to the
// count; a cofactor above 1 that is left at the end adds one more.
// All the arithmetic goes through a single restoring divider that produces one
// quotient bit per cycle, so each trial division is VALUE_BITS shift-subtract
// steps followed by one step to evaluate the outcome. The time from the
// acceptance of a request to the next one therefore grows with the number of
// trial divisions: it is shortest for 0 and 1, short for values with small
// factors, and longest for a 32-bit prime near the top of the range. The
// result is offered in the same cycle that the next request can be taken.
// The block works on one request at a time and holds in_stall high while it
// does. The result sits in an output register, so a new request is accepted
// while an earlier result still waits for out_stall to fall; the block only
// waits at the end of a request if the previous result has still not been
// taken.

module prime_factor_count
  import pfc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,

  input  logic [IN_BITS-1:0]    value,
  input  logic                  in_valid,
  output logic                  in_stall,

  output logic [COUNT_BITS-1:0] factor_count,
  output logic                  out_valid,
  input  logic                  out_stall
);

  // The divisor never exceeds the square root of the operand by more than two,
  // so it needs only half the operand width plus one bit.
  localparam int DIV_BITS  = (VALUE_BITS + 1) / 2 + 1;
  localparam int STEP_BITS = $clog2(VALUE_BITS);
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(VALUE_BITS - 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request
  localparam logic [1:0] S_DIV  = 2'd1;  // divider stepping through the bits
  localparam logic [1:0] S_EVAL = 2'd2;  // acting on quotient and remainder
  localparam logic [1:0] S_FIN  = 2'd3;  // handing the count to the output

  logic [1:0]            state;
  logic [STEP_BITS-1:0]  step;

  // Trial division working registers.
  logic [VALUE_BITS-1:0] n;      // the part of the operand not yet factored
  logic [DIV_BITS-1:0]   d;      // current candidate divisor
  logic [VALUE_BITS-1:0] quo;    // dividend shifting out, quotient shifting in
  logic [DIV_BITS-1:0]   rem;    // partial remainder
  logic [COUNT_BITS-1:0] count;

  logic [VALUE_BITS-1:0] operand;
  logic [DIV_BITS:0]     shifted;
  logic [DIV_BITS:0]     diff;
  logic                  fits;
  logic [DIV_BITS-1:0]   rem_step;
  logic                  past_root;
  logic                  out_free;

  // Bits above VALUE_BITS are dropped; a wider operand is zero extended.
  assign operand  = VALUE_BITS'(value);

  // One step of the restoring divider: bring down the next dividend bit and
  // subtract the divisor if it fits.
  assign shifted  = {rem, quo[VALUE_BITS-1]};
  assign diff     = shifted - {1'b0, d};
  assign fits     = (shifted >= {1'b0, d});
  assign rem_step = fits ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];

  // The divisor is larger than the quotient, so its square exceeds the
  // remaining value and no further trial is needed.
  assign past_root = (VALUE_BITS'(d) > quo);

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= STEP_LAST;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            step  <= STEP_LAST;
            state <= (operand < VALUE_BITS'(FIRST_DIVISOR)) ? S_FIN : S_DIV;
          end
        end
        S_DIV: begin
          step <= step - STEP_BITS'(1);
          if (step == '0) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          step  <= STEP_LAST;
          state <= past_root ? S_FIN : S_DIV;
        end
        S_FIN: begin
          if (out_free) begin
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  // The result is offered once the count is final and stays until it is taken;
  // a new count may replace a result in the very cycle that result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Datapath registers; they are always written before they are used.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          n     <= operand;
          quo   <= operand;
          rem   <= '0;
          d     <= DIV_BITS'(FIRST_DIVISOR);
          count <= '0;
        end
      end
      S_DIV: begin
        quo <= {quo[VALUE_BITS-2:0], fits};
        rem <= rem_step;
      end
      S_EVAL: begin
        rem <= '0;
        if (past_root) begin
          // Whatever is left above one is itself prime.
          if (n > VALUE_BITS'(UNIT_VALUE)) begin
            count <= count + COUNT_BITS'(1);
          end
        end else if (rem == '0) begin
          // Exact division: keep the quotient and try the same divisor again.
          count <= count + COUNT_BITS'(1);
          n     <= quo;
        end else begin
          // After 2 only odd candidates can divide what is left.
          quo <= n;
          if (d == DIV_BITS'(FIRST_DIVISOR)) begin
            d <= d + DIV_BITS'(1);
          end else begin
            d <= d + DIV_BITS'(2);
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          factor_count <= count;
        end
      end
    endcase
  end

endmodule

// ----- design/pfc_checker.sv -----
// Port-level checks for prime_factor_count, with the bind that attaches them.
// Depends on pfc_pkg and on the prime_factor_count module.
`timescale 1ns / 1ps

module pfc_checker
  import pfc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic [IN_BITS-1:0]    value,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [COUNT_BITS-1:0] factor_count,
  input logic                  out_valid,
  input logic                  out_stall
);

  // A result that is held back stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(factor_count))
    else $error("stalled result changed or vanished");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("new request accepted while one is in progress");

  // Zero and one have no prime factors and finish at once.
  a_trivial_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid && (value < IN_BITS'(2))
    |=> ##1 (out_valid && (factor_count == '0)))
    else $error("zero or one did not give an immediate count of zero");

  // The count can never exceed the operand width.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (VALUE_BITS >= 64) || (int'(factor_count) <= VALUE_BITS))
    else $error("factor count exceeds the operand width");

endmodule

bind prime_factor_count pfc_checker #(.VALUE_BITS(VALUE_BITS)) u_pfc_checker (.*);

// ----- test/prime_factor_count_test.sv -----
// Self-checking testbench for prime_factor_count, the prime factor counter.
// Depends on pfc_pkg and the prime_factor_count RTL; needs nothing else.
`timescale 1ns / 1ps

// The bench feeds one stream of requests through the value port. A short
// directed table comes first and a mix of random requests follows. Every
// accepted request has its expected factor count worked out when it is
// accepted, and that count is queued. Each result that leaves the block is
// compared with the oldest queued count.
//
// A single restoring divider does all of the block's arithmetic, so the cost
// of a request grows with the square root of the largest cofactor that trial
// division has to pass over. A prime near the top of the 32-bit range would
// take the longest of all. The random requests are therefore
// kept to values whose cofactors stay small:
//   - 16-bit values,
//   - 16-bit values shifted up, which gives long runs of twos,
//   - products of primes below 100, which fill the upper bits,
//   - now and then a 24-bit value, which can be a prime of some size.
// The directed table covers the wide patterns: all ones, the top bit alone,
// and alternating bits.

module prime_factor_count_test;
  import pfc_pkg::*;

  localparam int OPERAND_BITS  = VALUE_BITS_DEF;
  localparam int RANDOM_VALUES = 80;
  localparam int REPORT_LIMIT  = 10;
  localparam int DRAIN_CYCLES  = 64;
  localparam int NUM_ROWS      = 20;
  localparam int NUM_PRIMES    = 25;

  // This mask keeps only the bits that the block factors. It gives all ones
  // when the operand is 64 bits wide.
  localparam logic [63:0] OPERAND_MASK =
    (OPERAND_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << OPERAND_BITS) - 64'd1);

  // A directed row holds a request value. Where the count can be read off at
  // a glance, the row also holds that count and has its known flag set.
  // Every other row is checked against the predictor.
  typedef struct packed {
    logic [IN_BITS-1:0]    value;
    logic                  known;
    logic [COUNT_BITS-1:0] count;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    {32'd0,          1'b1, 6'd0},   // zero has no prime factors
    {32'd1,          1'b1, 6'd0},   // nor has one
    {32'd2,          1'b1, 6'd1},   // the smallest prime
    {32'd3,          1'b1, 6'd1},   // the first odd divisor
    {32'd4,          1'b1, 6'd2},   // the smallest square
    {32'hFFFF_FFFF,  1'b1, 6'd5},   // 3 * 5 * 17 * 257 * 65537
    {32'h8000_0000,  1'b1, 6'd31},  // the largest count a 32-bit value allows
    {32'hC000_0000,  1'b1, 6'd31},  // 3 * 2^30
    {32'h0001_0000,  1'b1, 6'd16},  // 2^16
    {32'd3486784401, 1'b1, 6'd20},  // 3^20
    {32'd1220703125, 1'b1, 6'd13},  // 5^13
    {32'd63001,      1'b0, 6'd0},   // the square of the prime 251
    {32'd65521,      1'b0, 6'd0},   // the largest 16-bit prime
    {32'd1048573,    1'b0, 6'd0},   // a prime just below 2^20
    {32'd30030,      1'b0, 6'd0},   // product of the first six primes
    {32'h5555_5555,  1'b0, 6'd0},   // alternating bits, low bit set
    {32'hAAAA_AAAA,  1'b0, 6'd0},   // alternating bits, top bit set
    {32'hFFFF_0000,  1'b0, 6'd0},
    {32'h0000_FFFF,  1'b0, 6'd0},
    {32'd2,          1'b1, 6'd1}    // again, right after the 16-bit all-ones value
  };

  localparam int SMALL_PRIMES [NUM_PRIMES] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71,
    73, 79, 83, 89, 97
  };

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic [IN_BITS-1:0]    value     = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [COUNT_BITS-1:0] factor_count;
  logic                  out_valid;
  logic                  out_stall = 1'b0;

  // Counts still owed by the block, the oldest at the front.
  logic [COUNT_BITS-1:0] pending_counts[$];
  int                    mismatch_total = 0;
  // When this is set the request side sends without gaps.
  bit                    in_calm = 1'b0;

  prime_factor_count u_dut (
    .clk          (clk),
    .rst          (rst),
    .value        (value),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .factor_count (factor_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Most gaps are absent or short. About one in ten is longer, which is
  // enough to reach every phase of the divider.
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  // Predictor: counts prime factors with multiplicity by plain trial division.
  // The block skips even divisors after 2, but that does not change the count.
  // The divisor bound is written as a quotient so that the square cannot
  // overflow.
  function automatic logic [COUNT_BITS-1:0] expected_count(input logic [IN_BITS-1:0] v);
    longint unsigned rest;
    longint unsigned divisor;
    int unsigned     total;
    rest    = 64'(v) & OPERAND_MASK;
    divisor = FIRST_DIVISOR;
    total   = 0;
    if (rest > UNIT_VALUE) begin
      while (divisor <= rest / divisor) begin
        while (rest % divisor == 0) begin
          total++;
          rest = rest / divisor;
        end
        divisor++;
      end
      if (rest > UNIT_VALUE) begin
        total++;
      end
    end
    return total[COUNT_BITS-1:0];
  endfunction

  // Random values are drawn from a mix that keeps the cofactors small, so that
  // no request runs long, while still reaching every bit of the port.
  function automatic logic [IN_BITS-1:0] random_value();
    int unsigned        kind;
    int unsigned        steps;
    longint unsigned    product;
    longint unsigned    prime;
    logic [IN_BITS-1:0] word;
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      word = $urandom_range(0, 24'hFF_FFFF);
    end else if (kind <= 5) begin
      word = $urandom_range(0, 16'hFFFF);
    end else if (kind <= 9) begin
      word = $urandom_range(1, 16'hFFFF);
      word = word << $urandom_range(0, 16);
    end else begin
      product = 1;
      steps   = $urandom_range(1, 31);
      repeat (steps) begin
        prime = SMALL_PRIMES[$urandom_range(0, NUM_PRIMES - 1)];
        if (product * prime <= 64'hFFFF_FFFF) begin
          product = product * prime;
        end
      end
      word = product[IN_BITS-1:0];
    end
    return word;
  endfunction

  // Presents one request and holds it until the block takes it. Then the
  // expected count is queued. If the gap is zero, in_valid stays high across
  // the boundary between two requests, so it is never lowered and raised in
  // the same time step.
  task automatic send_value(input logic [IN_BITS-1:0] v, input logic known,
                            input logic [COUNT_BITS-1:0] known_count);
    int unsigned gap;
    gap = in_calm ? 0 : idle_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    value    <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_counts.push_back(known ? known_count : expected_count(v));
  endtask

  // Request side: reset, then the directed table, then the random requests.
  // The final check follows once every count has come back.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int row = 0; row < NUM_ROWS; row++) begin
      send_value(DIRECTED_ROWS[row].value, DIRECTED_ROWS[row].known,
                 DIRECTED_ROWS[row].count);
    end

    for (int item = 0; item < RANDOM_VALUES; item++) begin
      if ($urandom_range(0, 15) == 0) begin
        in_calm = !in_calm;
      end
      send_value(random_value(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_counts.size() != 0) @(posedge clk);
    // Allow for a stray result that follows the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_total == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: random stalls, with stretches of none, and a check of
  // every result that is taken.
  always @(posedge clk) begin : result_side
    int unsigned           hold;
    logic [COUNT_BITS-1:0] wanted;
    static int unsigned    stall_left = 0;
    static bit             out_calm   = 1'b0;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left != 0) begin
        stall_left--;
      end else begin
        if ($urandom_range(0, 31) == 0) begin
          out_calm = !out_calm;
        end
        hold       = out_calm ? 0 : idle_length();
        out_stall  <= (hold != 0);
        stall_left = hold;
      end

      if (out_valid && !out_stall) begin
        if (pending_counts.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= REPORT_LIMIT) begin
            $display("%0t: factor_count %0d arrived with no request outstanding",
                     $realtime, factor_count);
          end
        end else begin
          wanted = pending_counts.pop_front();
          if (factor_count !== wanted) begin
            mismatch_total++;
            if (mismatch_total <= REPORT_LIMIT) begin
              $display("%0t: factor_count expected %0d, got %0d",
                       $realtime, wanted, factor_count);
            end
          end
        end
      end
    end
  end

  // Guard against a hang. A typical run needs well under this limit, and even
  // a run in which every random request were a 24-bit prime stays below it,
  // so this limit is several times the slowest correct run.
  initial begin
    #200_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- prime_factor_count.f -----
design/pfc_pkg.sv
design/prime_factor_count.sv
design/pfc_checker.sv
test/prime_factor_count_test.sv
